// ----- hdl/ece_pkg.sv -----
// ----------------------------------------------------------------------------
// Easing curve evaluator package
// Fixed-point formats, curve codes, constant tables and the per-stage datapath.
// ----------------------------------------------------------------------------
package ece_pkg;

  // Fraction bits of progress and result
  localparam int FRAC_BITS = 16;
  localparam int PW        = FRAC_BITS + 1;
  localparam int EW        = FRAC_BITS + 2;

  // Internal Q28 format
  localparam int IB = 28;
  localparam int QW = 36;
  localparam int MW = 2 * QW;
  localparam int RW = IB + 1;
  localparam int VW = 2 * IB + 3;

  // Register stages after the input stage
  localparam int NSTG = 24;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t ONE   = q_t'(1) <<< IB;
  localparam q_t HALF  = ONE >>> 1;
  localparam q_t TWO   = ONE <<< 1;
  localparam q_t THREE = ONE * 3;

  localparam q_t LN2_Q = 36'sd186065280;
  localparam q_t SIN_11 = -36'sd966;
  localparam q_t SIN_C [5] = '{36'sd43068, -36'sd1256767, 36'sd21392326,
                               -36'sd173399667, 36'sd421657428};

  // Reciprocals ceil(2^34 / k) for k = 1..10
  localparam int DIV_SH = 34;
  localparam logic [34:0] DIV_M [10] = '{35'd17179869184, 35'd8589934592,
                                         35'd5726623062, 35'd4294967296,
                                         35'd3435973837, 35'd2863311531,
                                         35'd2454267027, 35'd2147483648,
                                         35'd1908874354, 35'd1717986919};

  // Bounce pieces: A*x^2 - B*x + C
  localparam q_t BNC_A [4] = '{36'sd2030043136, 36'sd2436051763,
                               36'sd3239071596, 36'sd2899102925};
  localparam q_t BNC_B [4] = '{36'sd0, 36'sd2657511014,
                               36'sd5270852871, 36'sd5508295557};
  localparam q_t BNC_C [4] = '{36'sd0, 36'sd912680550,
                               36'sd2388555046, 36'sd2877628088};

  typedef enum logic [4:0] {
    K_LINEAR, K_QUAD_IN, K_QUAD_OUT, K_QUAD_IO, K_CUBIC_IN, K_CUBIC_OUT,
    K_CUBIC_IO, K_QUART_IN, K_QUART_OUT, K_QUART_IO, K_QUINT_IN, K_QUINT_OUT,
    K_QUINT_IO, K_SINE_IN, K_SINE_OUT, K_SINE_IO, K_CIRC_IN, K_CIRC_OUT,
    K_CIRC_IO, K_EXPO_IN, K_EXPO_OUT, K_EXPO_IO, K_ELASTIC_IN, K_ELASTIC_OUT,
    K_ELASTIC_IO, K_BACK_IN, K_BACK_OUT, K_BACK_IO, K_BOUNCE_IN, K_BOUNCE_OUT,
    K_BOUNCE_IO
  } kind_e;

  // One pipeline beat: every lane travels with the item
  typedef struct packed {
    logic [4:0]    kind;
    logic          lo;
    q_t            p;
    q_t            c;
    q_t            x;
    logic [2:0]    pn;
    q_t            pw;
    q_t            sa;
    q_t            sf2;
    q_t            st;
    logic          sneg;
    q_t            pe;
    q_t            pu;
    q_t            pr;
    q_t            pm;
    logic [3:0]    psh;
    q_t            qx;
    logic [RW-1:0] qr;
    logic [VW-1:0] qv;
    q_t            bx;
    logic [1:0]    bsel;
    q_t            bp2;
    q_t            ba;
    q_t            bb;
    q_t            bc;
    q_t            el;
    q_t            res;
  } st_t;

  // Q28 product, rounded half away from zero
  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [MW-1:0] pr;
    logic [MW-1:0] mag;
    logic [MW-1:0] sh;
    pr  = a * b;
    mag = pr[MW-1] ? unsigned'(-pr) : unsigned'(pr);
    sh  = (mag + (MW'(1) << (IB - 1))) >> IB;
    return pr[MW-1] ? -q_t'(sh[QW-1:0]) : q_t'(sh[QW-1:0]);
  endfunction

  // Halve, rounded half away from zero
  function automatic q_t half_q(input q_t a);
    q_t m;
    m = (a < 0) ? -a : a;
    m = (m + q_t'(1)) >>> 1;
    return (a < 0) ? -m : m;
  endfunction

  // Work of pipeline stage n on one beat
  function automatic st_t ece_stage(input int n, input st_t s);
    st_t           o;
    q_t            ma;
    q_t            mb;
    q_t            m;
    q_t            e;
    q_t            f;
    q_t            t;
    q_t            ax;
    q_t            rnd;
    logic [1:0]    quad;
    logic [VW-1:0] cand;
    logic [64:0]   dprod;
    int            i;
    int            k;
    o = s;

    // Power lane: x^n by repeated products
    if (n == 1) begin
      if (s.kind == K_QUAD_OUT) o.pw = mulq(s.p, TWO - s.p);
      else o.pw = mulq(s.x, s.x);
    end else if (n >= 2 && n <= 4) begin
      if (int'(s.pn) > n) o.pw = mulq(s.pw, s.x);
    end

    // Sine lane: reduce, square, Horner, finish
    if (n == 1) begin
      ax     = (s.sa < 0) ? -s.sa : s.sa;
      quad   = ax[IB+1:IB];
      f      = q_t'(ax[IB-1:0]);
      o.sa   = quad[0] ? ONE - f : f;
      o.sneg = (s.sa < 0) ^ quad[1];
    end else if (n == 2) begin
      o.sf2 = mulq(s.sa, s.sa);
    end else if (n >= 3 && n <= 7) begin
      o.st = SIN_C[n-3] + mulq(s.sf2, (n == 3) ? SIN_11 : s.st);
    end else if (n == 8) begin
      t = mulq(s.sa, s.st);
      if (t < 0) t = '0;
      if (t > ONE) t = ONE;
      o.st = s.sneg ? -t : t;
    end

    // Back core: x^3 - x * sin
    if (n == 9) o.bc = s.pw - mulq(s.x, s.st);

    // Exponential lane: split, series terms, final shift, elastic product
    if (n == 1) begin
      e     = (s.pe > 0) ? '0 : s.pe;
      o.psh = 4'(-(e >>> IB));
      f     = q_t'(e[IB-1:0]);
      o.pu  = mulq(f, LN2_Q);
      o.pr  = ONE;
    end else if (n >= 2 && n <= 20 && !n[0]) begin
      o.pm = mulq(s.pu, s.pr);
    end else if (n >= 3 && n <= 21 && n[0]) begin
      k     = 10 - ((n - 3) >>> 1);
      dprod = 65'(s.pm[29:0]) * 65'(DIV_M[k-1]);
      o.pr  = ONE + q_t'(dprod[64:DIV_SH]);
    end else if (n == 22) begin
      rnd  = (s.psh == 4'd0) ? '0 : (q_t'(1) << (s.psh - 4'd1));
      o.pr = (s.pr + rnd) >>> s.psh;
    end else if (n == 23) begin
      o.el = mulq(s.st, s.pr);
    end

    // Square root lane: operand, then two root bits per stage
    if (n == 1) begin
      ma = s.p;
      mb = s.p;
      if (s.kind == K_CIRC_OUT) ma = TWO - s.p;
      if (s.kind == K_CIRC_IO && !s.lo) begin
        ma = THREE - (s.p <<< 1);
        mb = (s.p <<< 1) - ONE;
      end
      m = mulq(ma, mb);
      unique case (s.kind)
        K_CIRC_IN:  o.qx = ONE - m;
        K_CIRC_OUT: o.qx = m;
        K_CIRC_IO:  o.qx = s.lo ? ONE - (m <<< 2) : m;
        default:    o.qx = '0;
      endcase
    end else if (n == 2) begin
      o.qv = (s.qx <= 0) ? '0 : (VW'(s.qx[IB:0]) << IB);
      o.qr = '0;
    end else if (n >= 3 && n <= 17) begin
      for (int d = 0; d < 2; d++) begin
        i = IB - 2 * (n - 3) - d;
        if (i >= 0) begin
          cand = (VW'(o.qr) << (i + 1)) + (VW'(1) << (2 * i));
          if (o.qv >= cand) begin
            o.qv = o.qv - cand;
            o.qr = o.qr | (RW'(1) << i);
          end
        end
      end
    end

    // Bounce lane: piece select, products, sum
    if (n == 1) begin
      if (s.bx * 11 < ONE * 4) o.bsel = 2'd0;
      else if (s.bx * 11 < ONE * 8) o.bsel = 2'd1;
      else if (s.bx * 10 < ONE * 9) o.bsel = 2'd2;
      else o.bsel = 2'd3;
      o.bp2 = mulq(s.bx, s.bx);
      o.bb  = mulq(s.bx, BNC_B[o.bsel]);
    end else if (n == 2) begin
      o.ba = mulq(s.bp2, BNC_A[s.bsel]);
    end else if (n == 3) begin
      o.ba = s.ba - s.bb + BNC_C[s.bsel];
    end

    // Combine lanes per curve
    if (n == 24) begin
      m = q_t'(s.qr);
      unique case (s.kind)
        K_QUAD_IN, K_QUAD_OUT, K_CUBIC_IN, K_QUART_IN, K_QUINT_IN: o.res = s.pw;
        K_CUBIC_OUT, K_QUART_OUT, K_QUINT_OUT: o.res = ONE - s.pw;
        K_QUAD_IO:    o.res = s.lo ? (s.pw <<< 1) : ONE - (s.pw <<< 1);
        K_CUBIC_IO:   o.res = s.lo ? (s.pw <<< 2) : ONE - (s.pw <<< 2);
        K_QUART_IO:   o.res = s.lo ? (s.pw <<< 3) : ONE - (s.pw <<< 3);
        K_QUINT_IO:   o.res = s.lo ? (s.pw <<< 4) : ONE - (s.pw <<< 4);
        K_SINE_IN:    o.res = s.st + ONE;
        K_SINE_OUT:   o.res = s.st;
        K_SINE_IO:    o.res = half_q(ONE - s.st);
        K_CIRC_IN:    o.res = ONE - m;
        K_CIRC_OUT:   o.res = m;
        K_CIRC_IO:    o.res = s.lo ? half_q(ONE - m) : half_q(m + ONE);
        K_EXPO_IN:    o.res = (s.p == 0) ? '0 : s.pr;
        K_EXPO_OUT:   o.res = (s.p == ONE) ? ONE : ONE - s.pr;
        K_EXPO_IO: begin
          if (s.p == 0) o.res = '0;
          else if (s.p == ONE) o.res = ONE;
          else o.res = s.lo ? half_q(s.pr) : ONE - half_q(s.pr);
        end
        K_ELASTIC_IN:  o.res = s.el;
        K_ELASTIC_OUT: o.res = s.el + ONE;
        K_ELASTIC_IO:  o.res = s.lo ? half_q(s.el) : half_q(s.el + TWO);
        K_BACK_IN:     o.res = s.bc;
        K_BACK_OUT:    o.res = ONE - s.bc;
        K_BACK_IO:     o.res = s.lo ? half_q(s.bc) : half_q(ONE - s.bc) + HALF;
        K_BOUNCE_IN:   o.res = ONE - s.ba;
        K_BOUNCE_OUT:  o.res = s.ba;
        K_BOUNCE_IO:   o.res = s.lo ? half_q(ONE - s.ba) : half_q(s.ba) + HALF;
        default:       o.res = s.p;
      endcase
    end
    return o;
  endfunction

endpackage

// ----- hdl/ece_prep.sv -----
// ----------------------------------------------------------------------------
// Easing input stage
// Clamps progress, converts it to Q28 and forms the operands of every lane.
// ----------------------------------------------------------------------------
module ece_prep (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [4:0]             kind_i,
  input  logic [ece_pkg::PW-1:0] progress_i,
  output logic                   valid_o,
  output ece_pkg::st_t           beat_o
);
  import ece_pkg::*;

  localparam logic [PW-1:0] PROG_ONE = PW'(1) << FRAC_BITS;

  logic [PW-1:0] prog;
  st_t           beat_d;
  st_t           beat_q;
  logic          valid_q;

  // Form lane operands
  always_comb begin
    beat_d      = '0;
    prog        = (progress_i > PROG_ONE) ? PROG_ONE : progress_i;
    beat_d.kind = kind_i;
    beat_d.p    = q_t'(prog) <<< (IB - FRAC_BITS);
    beat_d.c    = ONE - beat_d.p;
    beat_d.lo   = beat_d.p < HALF;

    unique case (kind_i)
      K_QUAD_IN, K_CUBIC_IN, K_QUART_IN, K_QUINT_IN, K_BACK_IN: beat_d.x = beat_d.p;
      K_QUAD_OUT, K_CUBIC_OUT, K_QUART_OUT, K_QUINT_OUT, K_BACK_OUT: beat_d.x = beat_d.c;
      K_QUAD_IO, K_CUBIC_IO, K_QUART_IO, K_QUINT_IO:
        beat_d.x = beat_d.lo ? beat_d.p : beat_d.c;
      K_BACK_IO:
        beat_d.x = beat_d.lo ? (beat_d.p <<< 1) : TWO - (beat_d.p <<< 1);
      default: beat_d.x = beat_d.p;
    endcase

    unique case (kind_i)
      K_CUBIC_IN, K_CUBIC_OUT, K_CUBIC_IO, K_BACK_IN, K_BACK_OUT, K_BACK_IO:
        beat_d.pn = 3'd3;
      K_QUART_IN, K_QUART_OUT, K_QUART_IO: beat_d.pn = 3'd4;
      K_QUINT_IN, K_QUINT_OUT, K_QUINT_IO: beat_d.pn = 3'd5;
      default: beat_d.pn = 3'd2;
    endcase

    // Sine argument in quarter turns
    unique case (kind_i)
      K_SINE_IN:     beat_d.sa = beat_d.p - ONE;
      K_SINE_OUT:    beat_d.sa = beat_d.p;
      K_SINE_IO:     beat_d.sa = (beat_d.p <<< 1) + ONE;
      K_ELASTIC_IN:  beat_d.sa = q_t'(13) * beat_d.p;
      K_ELASTIC_OUT: beat_d.sa = -(q_t'(13) * (beat_d.p + ONE));
      K_ELASTIC_IO:
        beat_d.sa = beat_d.lo ? q_t'(26) * beat_d.p : -(q_t'(26) * beat_d.p);
      K_BACK_IN, K_BACK_OUT, K_BACK_IO: beat_d.sa = beat_d.x <<< 1;
      default: beat_d.sa = '0;
    endcase

    // Power-of-two exponent
    unique case (kind_i)
      K_EXPO_IN, K_ELASTIC_IN:   beat_d.pe = q_t'(10) * (beat_d.p - ONE);
      K_EXPO_OUT, K_ELASTIC_OUT: beat_d.pe = -(q_t'(10) * beat_d.p);
      K_EXPO_IO, K_ELASTIC_IO:
        beat_d.pe = beat_d.lo ? q_t'(20) * beat_d.p - q_t'(10) * ONE
                              : q_t'(10) * ONE - q_t'(20) * beat_d.p;
      default: beat_d.pe = '0;
    endcase

    // Bounce argument
    unique case (kind_i)
      K_BOUNCE_IN:  beat_d.bx = beat_d.c;
      K_BOUNCE_OUT: beat_d.bx = beat_d.p;
      K_BOUNCE_IO:
        beat_d.bx = beat_d.lo ? ONE - (beat_d.p <<< 1) : (beat_d.p <<< 1) - ONE;
      default: beat_d.bx = '0;
    endcase
  end

  // Hold valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Capture operands
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ----- hdl/ece_out.sv -----
// ----------------------------------------------------------------------------
// Easing output stage
// Rounds the Q28 curve value to the output format, saturates and strobes it.
// ----------------------------------------------------------------------------
module ece_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  ece_pkg::q_t                   res_i,
  output logic                          done_o,
  output logic signed [ece_pkg::EW-1:0] eased_value_o
);
  import ece_pkg::*;

  localparam int SH = IB - FRAC_BITS;
  localparam q_t SAT_HI = (q_t'(2) <<< FRAC_BITS) - q_t'(1);
  localparam q_t SAT_LO = -(q_t'(2) <<< FRAC_BITS);

  q_t                   mag;
  q_t                   rv;
  logic signed [EW-1:0] value_d;
  logic signed [EW-1:0] value_q;
  logic                 done_q;

  // Round half away from zero, then saturate
  always_comb begin
    mag = (res_i < 0) ? -res_i : res_i;
    mag = (mag + (q_t'(1) <<< (SH - 1))) >>> SH;
    rv  = (res_i < 0) ? -mag : mag;
    if (rv > SAT_HI) rv = SAT_HI;
    if (rv < SAT_LO) rv = SAT_LO;
    value_d = rv[EW-1:0];
  end

  // Strobe result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      value_q <= value_d;
    end
  end

  assign done_o        = done_q;
  assign eased_value_o = value_q;

endmodule

// ----- hdl/easing_curve_evaluator_unit.sv -----
// ----------------------------------------------------------------------------
// Easing curve evaluator unit
// An accepted start passes the input, datapath and output registers before the done strobe.
// Throughput: one item per cycle; busy_o stays low and results are never held.
// Depth is set by the ten-term exponential series, two stages per term.
// Reset clears only the valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module easing_curve_evaluator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [4:0]                    kind_i,
  input  logic [ece_pkg::PW-1:0]        progress_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic signed [ece_pkg::EW-1:0] eased_value_o
);
  import ece_pkg::*;

  localparam int LATENCY = NSTG + 2;

  logic accept;
  logic vld0;
  st_t  beat0;
  logic vld_q [1:NSTG];
  st_t  s_q   [1:NSTG];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  ece_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .kind_i     (kind_i),
    .progress_i (progress_i),
    .valid_o    (vld0),
    .beat_o     (beat0)
  );

  // Advance beats through the datapath stages
  for (genvar g = 1; g <= NSTG; g++) begin : g_stage
    logic prev_vld;
    st_t  prev_beat;
    if (g == 1) begin : g_first
      assign prev_vld  = vld0;
      assign prev_beat = beat0;
    end else begin : g_next
      assign prev_vld  = vld_q[g-1];
      assign prev_beat = s_q[g-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (prev_vld) begin
        s_q[g] <= ece_stage(g, prev_beat);
      end
    end
  end

  ece_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (vld_q[NSTG]),
    .res_i         (s_q[NSTG].res),
    .done_o        (done_o),
    .eased_value_o (eased_value_o)
  );

  // Every accepted item gives a strobe after the fixed latency
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("missing result strobe after accepted item");

  // No strobe without an item accepted at the matching time
  a_latency_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result strobe without matching accepted item");

  // Last stage valid turns into a strobe on the next cycle
  a_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTG] |=> done_o)
    else $error("last stage beat not delivered");

endmodule
